// ----- sv/sort_values_ascending_macros.svh -----
// Assertion macros for the run sorter.
`ifndef SORT_VALUES_ASCENDING_MACROS_SVH
`define SORT_VALUES_ASCENDING_MACROS_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define SVA_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorter check failed");
// Checked on every edge, reset included.
`define SVA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("sorter check failed");
`else
`define SVA_ASSERT_RST(label, prop)
`define SVA_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- sv/sva_pkg.sv -----
package sva_pkg;

  localparam int unsigned VALUE_W            = 32;
  localparam int unsigned DEFAULT_MAX_VALUES = 32;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;  // load a new word into the chain
    logic shift;   // move every word one cell toward the head
  } cell_ctrl_t;

endpackage

// ----- sv/sort_values_ascending.sv -----
// Run sorter built as an insertion chain of MAX_VALUES cells.
//
// Input channel (in_valid_i / in_stall_o, value_i, last_value_i): one signed
// 32-bit word per cycle when not stalled. Each word is inserted into the
// chain, kept in ascending order from cell 0; last_value_i marks the final
// word of a run. Words that arrive while the chain is full are dropped and
// the run is flagged; the flag rides on every result of that run (overflow_o).
//
// Output channel (out_valid_o / out_stall_i, sorted_value_o, last_result_o,
// overflow_o): after the marked word is accepted, the chain drains from cell 0,
// one per cycle unless stalled, smallest first; last_result_o marks the greatest.
//
// Timing: the accepted marked word sets the draining register, and the head
// is then popped into the output register; results follow one per cycle
// while the receiver does not stall. The drain rate is set by the single
// output register; the chain shifts only when it is free.
// While draining, in_stall_o is high; the next run may load as soon as the
// last word has left the chain, even while it still sits in the output
// register. A stalled receiver freezes the output register and the chain.
// Reset empties the chain, clears the overflow flag and the output valid.
module sort_values_ascending #(
  parameter int unsigned MAX_VALUES = sva_pkg::DEFAULT_MAX_VALUES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sva_pkg::VALUE_W-1:0]  value_i,
  input  logic                                last_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sva_pkg::VALUE_W-1:0]  sorted_value_o,
  output logic                                last_result_o,
  output logic                                overflow_o
);
  import sva_pkg::*;

  `include "sort_values_ascending_macros.svh"

  cell_ctrl_t ctrl;

  logic signed [VALUE_W-1:0] cell_value [MAX_VALUES];
  logic [MAX_VALUES-1:0]     cell_valid;
  logic [MAX_VALUES-1:0]     cell_take;

  logic signed [VALUE_W-1:0] prev_value [MAX_VALUES];
  logic [MAX_VALUES-1:0]     prev_valid;
  logic [MAX_VALUES-1:0]     prev_take;
  logic signed [VALUE_W-1:0] next_value [MAX_VALUES];
  logic [MAX_VALUES-1:0]     next_valid;

  logic draining_d, draining_q;
  logic dropped_d, dropped_q;
  logic out_valid_d, out_valid_q;
  logic signed [VALUE_W-1:0] sorted_value_q;
  logic last_result_q, overflow_q;

  logic in_accept, full, out_free, pop, pop_last;

  assign in_stall_o = draining_q;
  assign in_accept  = in_valid_i && !draining_q;
  assign full       = cell_valid[MAX_VALUES-1];
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = draining_q && out_free;
  // head holds the last word when its neighbor is empty
  assign pop_last   = pop && !cell_valid[1];

  assign ctrl.insert = in_accept && !full;
  assign ctrl.shift  = pop;

  // chain neighbors; the head sees an always-valid, never-taking neighbor
  for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_value[i] = '0;
      assign prev_valid[i] = 1'b1;
      assign prev_take[i]  = 1'b0;
    end else begin : g_body
      assign prev_value[i] = cell_value[i-1];
      assign prev_valid[i] = cell_valid[i-1];
      assign prev_take[i]  = cell_take[i-1];
    end
    if (i == MAX_VALUES - 1) begin : g_tail
      assign next_value[i] = '0;
      assign next_valid[i] = 1'b0;
    end else begin : g_mid
      assign next_value[i] = cell_value[i+1];
      assign next_valid[i] = cell_valid[i+1];
    end

    sva_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (value_i),
      .prev_value_i (prev_value[i]),
      .prev_valid_i (prev_valid[i]),
      .prev_take_i  (prev_take[i]),
      .next_value_i (next_value[i]),
      .next_valid_i (next_valid[i]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .take_o       (cell_take[i])
    );
  end

  always_comb begin
    draining_d = draining_q;
    dropped_d  = dropped_q;
    if (in_accept) begin
      if (full) begin
        dropped_d = 1'b1;
      end
      if (last_value_i) begin
        draining_d = 1'b1;
      end
    end
    if (pop_last) begin
      draining_d = 1'b0;
      dropped_d  = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q  <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      draining_q  <= draining_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sorted_value_q <= cell_value[0];
      last_result_q  <= !cell_valid[1];
      overflow_q     <= dropped_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = sorted_value_q;
  assign last_result_o  = last_result_q;
  assign overflow_o     = overflow_q;

  // occupied cells always form a prefix starting at the head
  `SVA_ASSERT_RST(a_valid_prefix, (cell_valid & (cell_valid + 1'b1)) == '0)
  // a draining chain never runs empty before its last word leaves
  `SVA_ASSERT_RST(a_drain_nonempty, draining_q |-> cell_valid[0])
  // the marked word starts the drain on the next cycle
  `SVA_ASSERT_RST(a_mark_starts_drain, (in_accept && last_value_i) |=> draining_q)
  // the last result ends the drain
  `SVA_ASSERT_RST(a_last_ends_drain, pop_last |=> !draining_q)

endmodule

// ----- sv/sva_cell.sv -----
module sva_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sva_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [sva_pkg::VALUE_W-1:0]  new_value_i,
  // neighbor toward the head
  input  logic signed [sva_pkg::VALUE_W-1:0]  prev_value_i,
  input  logic                                prev_valid_i,
  input  logic                                prev_take_i,
  // neighbor toward the tail
  input  logic signed [sva_pkg::VALUE_W-1:0]  next_value_i,
  input  logic                                next_valid_i,
  output logic signed [sva_pkg::VALUE_W-1:0]  value_o,
  output logic                                valid_o,
  output logic                                take_o
);
  import sva_pkg::*;

  logic signed [VALUE_W-1:0] value_d, value_q;
  logic                      valid_d, valid_q;

  // Cell yields its slot when empty or when the new word sorts before it.
  assign take_o = !valid_q || (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (take_o) begin
        value_d = (prev_take_i && prev_valid_i) ? prev_value_i : new_value_i;
      end
      valid_d = valid_q | prev_valid_i;
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule
